[sv/msc_pkg.sv]
// Shared types, opcode and function codes, and defaults for the MIPS subset core.
// Used by every module of the core; depends on nothing.
`timescale 1ns / 1ps

package msc_pkg;

    localparam int MEM_DEPTH_DEF = 4096;

    localparam logic [31:0] STACK_START_RST = 32'd16777216;
    localparam logic [31:0] SENTINEL_RST    = 32'hFFFF_FFFF;
    localparam logic [31:0] ADDR_LIMIT      = 32'd16777216;

    // Width of a non-faulting word address (at most the address limit itself).
    localparam int ADDR_SRC_W = 25;

    localparam logic [4:0] REG_V0 = 5'd2;
    localparam logic [4:0] REG_SP = 5'd29;
    localparam logic [4:0] REG_RA = 5'd31;

    localparam logic CFG_STACK_START     = 1'b0;
    localparam logic CFG_RETURN_SENTINEL = 1'b1;

    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_J       = 6'd2;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_ADDIU   = 6'd9;
    localparam logic [5:0] OP_SLTI    = 6'd10;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_SW      = 6'd43;

    localparam logic [5:0] FN_NOP  = 6'd0;
    localparam logic [5:0] FN_JR   = 6'd8;
    localparam logic [5:0] FN_MFLO = 6'd18;
    localparam logic [5:0] FN_MULT = 6'd24;
    localparam logic [5:0] FN_ADDU = 6'd33;
    localparam logic [5:0] FN_MOVE = 6'd37;

    typedef enum logic [1:0] {
        CLS_NOP = 2'd0,
        CLS_R   = 2'd1,
        CLS_I   = 2'd2,
        CLS_J   = 2'd3
    } t_class;

    typedef struct packed {
        logic        we;
        logic [4:0]  addr;
        logic [31:0] data;
    } t_rf_wr;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        halted;
        t_class      cls;
        logic        wr;
        logic        from_mem;
        logic [4:0]  idx;
        logic [31:0] val;
        logic        stored;
        logic        fault;
        logic [31:0] rc;
        logic [31:0] ic;
        logic [31:0] jc;
    } t_wb_rec;

endpackage

[sv/mips_subset_single_cycle_core.sv]
// Top level of the MIPS subset core: decode and execute stage, write-back and result
// register, configuration registers and HI/LO/PC state.
// Depends on msc_pkg, msc_regfile, msc_dmem and msc_addr_mod.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready   instruction word
// m_axis    out        m_axis_tvalid / m_axis_tready   result of one instruction
// cfg       in         i_cfg_we                        register index and data
//
// An instruction is registered on acceptance and executes in the next cycle; its
// result is registered for write-back and shown from there. One instruction per
// cycle is sustained while no stall holds execute. A load or store that does not
// fault is held in execute until the two-step index reduction is done when
// MEM_DEPTH is not a power of two. After reset the data memory is swept to zero
// word by word, and no request is accepted until the sweep is done. A stalled result
// holds execute and then the input; register operands are forwarded from write-back.

module mips_subset_single_cycle_core #(
    parameter int MEM_DEPTH = msc_pkg::MEM_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // instruction[31:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // next_pc[31:0], reg_index[36:32], reg_value[68:37], r_count[100:69],
    // i_count[132:101], j_count[164:133], return_value[196:165], zero[199:197]
    output logic [199:0] m_axis_tdata,
    // halted[0], instr_class[2:1], reg_written[3], store_done[4], mem_fault[5], zero[7:6]
    output logic [7:0]   m_axis_tuser,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    localparam int AW = $clog2(MEM_DEPTH);

    logic [31:0] r_stack_start;
    logic [31:0] r_sentinel;
    logic [31:0] r_pc;
    logic [31:0] r_hi;
    logic [31:0] r_lo;
    logic [31:0] r_rc;
    logic [31:0] r_ic;
    logic [31:0] r_jc;
    logic [31:0] r_v0;

    logic        r_ex_valid;
    logic [31:0] r_ex_ins;
    logic        r_fa_hit;
    logic        r_fb_hit;
    logic [31:0] r_fa_val;
    logic [31:0] r_fb_val;

    logic              r_wb_valid;
    msc_pkg::t_wb_rec  r_wb;
    msc_pkg::t_wb_rec  n_wb;

    logic [31:0] n_hi;
    logic [31:0] n_lo;

    logic        accept;
    logic        ex_adv;
    logic        wb_adv;
    logic        wb_free;
    logic        clr_busy;

    logic [31:0] rf_qa;
    logic [31:0] rf_qb;
    logic [31:0] dm_q;
    logic [31:0] wb_value;
    msc_pkg::t_rf_wr rf_wr;

    logic [5:0]  op;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [5:0]  fn;
    logic [31:0] imm;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] seq;
    logic [31:0] addr;
    logic        is_mem;
    logic        is_load;
    logic        fault;
    logic        mod_req;
    logic        mod_done;
    logic        mod_ok;
    logic [AW-1:0] mem_index;
    logic signed [63:0] prod;
    logic        wr_raw;
    logic        fwd_a;
    logic        fwd_b;

    // Handshake and stage advance.
    assign wb_adv        = r_wb_valid && m_axis_tready;
    assign wb_free       = !r_wb_valid || wb_adv;
    assign mod_ok        = !mod_req || mod_done;
    assign ex_adv        = r_ex_valid && wb_free && mod_ok;
    assign s_axis_tready = !clr_busy && (!r_ex_valid || ex_adv);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Write-back value and register file write port.
    assign wb_value   = r_wb.from_mem ? dm_q : r_wb.val;
    assign rf_wr.we   = wb_adv && r_wb.wr;
    assign rf_wr.addr = r_wb.idx;
    assign rf_wr.data = wb_value;

    msc_regfile u_regfile (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_re          (accept),
        .i_ra          (s_axis_tdata[25:21]),
        .i_rb          (s_axis_tdata[20:16]),
        .i_wr          (rf_wr),
        .i_clr_sp      (i_cfg_we && i_cfg_index == msc_pkg::CFG_STACK_START),
        .i_clr_ra      (i_cfg_we && i_cfg_index == msc_pkg::CFG_RETURN_SENTINEL),
        .i_stack_start (r_stack_start),
        .i_sentinel    (r_sentinel),
        .o_qa          (rf_qa),
        .o_qb          (rf_qb)
    );

    // Operand selection: a pending write-back wins, then a held operand, then the RAM.
    assign op  = r_ex_ins[31:26];
    assign rs  = r_ex_ins[25:21];
    assign rt  = r_ex_ins[20:16];
    assign rd  = r_ex_ins[15:11];
    assign fn  = r_ex_ins[5:0];
    assign imm = {{16{r_ex_ins[15]}}, r_ex_ins[15:0]};

    assign fwd_a = r_wb_valid && r_wb.wr && r_wb.idx == rs;
    assign fwd_b = r_wb_valid && r_wb.wr && r_wb.idx == rt;
    assign a = fwd_a ? wb_value : (r_fa_hit ? r_fa_val : rf_qa);
    assign b = fwd_b ? wb_value : (r_fb_hit ? r_fb_val : rf_qb);

    assign seq     = r_pc + 32'd4;
    assign addr    = a + imm;
    assign is_load = op == msc_pkg::OP_LW;
    assign is_mem  = is_load || op == msc_pkg::OP_SW;
    assign fault   = addr[31] || addr > msc_pkg::ADDR_LIMIT;
    assign mod_req = r_ex_valid && is_mem && !fault;
    assign prod    = $signed(a) * $signed(b);

    msc_addr_mod #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_addr_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .i_clear (ex_adv),
        .i_addr  (addr[msc_pkg::ADDR_SRC_W-1:0]),
        .o_done  (mod_done),
        .o_index (mem_index)
    );

    msc_dmem #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (ex_adv && mod_req && !is_load),
        .i_re    (ex_adv && mod_req && is_load),
        .i_addr  (mem_index),
        .i_wd    (b),
        .o_q     (dm_q),
        .o_busy  (clr_busy)
    );

    always_comb begin
        n_wb          = '0;
        n_wb.next_pc  = seq;
        n_wb.cls      = msc_pkg::CLS_I;
        n_hi          = r_hi;
        n_lo          = r_lo;
        wr_raw        = 1'b0;
        unique case (op) inside
            msc_pkg::OP_SPECIAL: begin
                if (fn == msc_pkg::FN_NOP) begin
                    n_wb.cls = msc_pkg::CLS_NOP;
                end else begin
                    n_wb.cls = msc_pkg::CLS_R;
                    unique case (fn) inside
                        msc_pkg::FN_ADDU, msc_pkg::FN_MOVE: begin
                            wr_raw   = 1'b1;
                            n_wb.idx = rd;
                            n_wb.val = a + b;
                        end
                        msc_pkg::FN_MULT: begin
                            n_lo = prod[31:0];
                            n_hi = prod[63:32];
                        end
                        msc_pkg::FN_MFLO: begin
                            wr_raw   = 1'b1;
                            n_wb.idx = rd;
                            n_wb.val = r_lo;
                        end
                        msc_pkg::FN_JR: begin
                            n_wb.next_pc = a;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            msc_pkg::OP_J, msc_pkg::OP_JAL: begin
                n_wb.cls     = msc_pkg::CLS_J;
                n_wb.next_pc = {seq[31:28], r_ex_ins[25:0], 2'b00};
                if (op == msc_pkg::OP_JAL) begin
                    wr_raw   = 1'b1;
                    n_wb.idx = msc_pkg::REG_RA;
                    n_wb.val = seq;
                end
            end
            msc_pkg::OP_ADDIU: begin
                wr_raw   = 1'b1;
                n_wb.idx = rt;
                n_wb.val = a + imm;
            end
            msc_pkg::OP_SLTI: begin
                wr_raw   = 1'b1;
                n_wb.idx = rt;
                n_wb.val = {31'd0, $signed(a) < $signed(imm)};
            end
            msc_pkg::OP_LW, msc_pkg::OP_SW: begin
                n_wb.fault = fault;
                if (!fault) begin
                    if (is_load) begin
                        wr_raw        = 1'b1;
                        n_wb.idx      = rt;
                        n_wb.from_mem = 1'b1;
                    end else begin
                        n_wb.stored = 1'b1;
                    end
                end
            end
            msc_pkg::OP_BEQ, msc_pkg::OP_BNE: begin
                if ((op == msc_pkg::OP_BEQ) == (a == b)) begin
                    n_wb.next_pc = seq + {imm[29:0], 2'b00};
                end
            end
            default: begin
            end
        endcase

        n_wb.wr = wr_raw && n_wb.idx != 5'd0;
        if (!n_wb.wr) begin
            n_wb.idx      = 5'd0;
            n_wb.val      = 32'd0;
            n_wb.from_mem = 1'b0;
        end
        n_wb.halted = n_wb.next_pc == r_sentinel;
        n_wb.rc     = r_rc + {31'd0, n_wb.cls == msc_pkg::CLS_R};
        n_wb.ic     = r_ic + {31'd0, n_wb.cls == msc_pkg::CLS_I};
        n_wb.jc     = r_jc + {31'd0, n_wb.cls == msc_pkg::CLS_J};
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_start <= msc_pkg::STACK_START_RST;
            r_sentinel    <= msc_pkg::SENTINEL_RST;
            r_pc          <= 32'd0;
            r_hi          <= 32'd0;
            r_lo          <= 32'd0;
            r_rc          <= 32'd0;
            r_ic          <= 32'd0;
            r_jc          <= 32'd0;
            r_v0          <= 32'd0;
            r_ex_valid    <= 1'b0;
            r_wb_valid    <= 1'b0;
            r_fa_hit      <= 1'b0;
            r_fb_hit      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == msc_pkg::CFG_STACK_START) begin
                    r_stack_start <= i_cfg_data;
                end else begin
                    r_sentinel <= i_cfg_data;
                end
            end

            if (accept) begin
                r_ex_valid <= 1'b1;
                r_fa_hit   <= 1'b0;
                r_fb_hit   <= 1'b0;
            end else if (ex_adv) begin
                r_ex_valid <= 1'b0;
            end else if (r_ex_valid) begin
                r_fa_hit <= 1'b1;
                r_fb_hit <= 1'b1;
            end

            if (ex_adv) begin
                r_pc       <= n_wb.next_pc;
                r_hi       <= n_hi;
                r_lo       <= n_lo;
                r_rc       <= n_wb.rc;
                r_ic       <= n_wb.ic;
                r_jc       <= n_wb.jc;
                r_wb_valid <= 1'b1;
            end else if (wb_adv) begin
                r_wb_valid <= 1'b0;
            end

            if (rf_wr.we && rf_wr.addr == msc_pkg::REG_V0) begin
                r_v0 <= rf_wr.data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ex_ins <= s_axis_tdata;
        end
        if (!accept && r_ex_valid && !ex_adv) begin
            r_fa_val <= a;
            r_fb_val <= b;
        end
        if (ex_adv) begin
            r_wb <= n_wb;
        end
    end

    assign m_axis_tvalid = r_wb_valid;
    assign m_axis_tdata  = {3'b000,
                            (r_wb.wr && r_wb.idx == msc_pkg::REG_V0) ? wb_value : r_v0,
                            r_wb.jc, r_wb.ic, r_wb.rc,
                            wb_value, r_wb.idx, r_wb.next_pc};
    assign m_axis_tuser  = {2'b00, r_wb.fault, r_wb.stored, r_wb.wr, r_wb.cls, r_wb.halted};

endmodule

[sv/msc_regfile.sv]
// Register file: 32 words in a synchronous RAM with two registered read ports and one
// write port, plus per-entry valid bits that stand in for the reset contents.
// Depends on msc_pkg.
`timescale 1ns / 1ps

module msc_regfile (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_re,
    input  logic [4:0]        i_ra,
    input  logic [4:0]        i_rb,
    input  msc_pkg::t_rf_wr   i_wr,
    input  logic              i_clr_sp,
    input  logic              i_clr_ra,
    input  logic [31:0]       i_stack_start,
    input  logic [31:0]       i_sentinel,
    output logic [31:0]       o_qa,
    output logic [31:0]       o_qb
);

    logic [31:0] mem [32];
    logic [31:0] r_valid;
    logic [31:0] r_qa;
    logic [31:0] r_qb;
    logic        r_va;
    logic        r_vb;
    logic [4:0]  r_ra;
    logic [4:0]  r_rb;

    function automatic logic [31:0] rst_val(input logic [4:0] idx,
                                            input logic [31:0] sp,
                                            input logic [31:0] ra);
        logic [31:0] v;
        v = 32'd0;
        if (idx == msc_pkg::REG_SP) v = sp;
        if (idx == msc_pkg::REG_RA) v = ra;
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_re) begin
            r_qa <= (i_wr.we && i_wr.addr == i_ra) ? i_wr.data : mem[i_ra];
            r_qb <= (i_wr.we && i_wr.addr == i_rb) ? i_wr.data : mem[i_rb];
            r_ra <= i_ra;
            r_rb <= i_rb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 32'd0;
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
        end else begin
            if (i_re) begin
                r_va <= r_valid[i_ra] || (i_wr.we && i_wr.addr == i_ra);
                r_vb <= r_valid[i_rb] || (i_wr.we && i_wr.addr == i_rb);
            end
            if (i_wr.we) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_clr_sp) begin
                r_valid[msc_pkg::REG_SP] <= 1'b0;
            end
            if (i_clr_ra) begin
                r_valid[msc_pkg::REG_RA] <= 1'b0;
            end
        end
    end

    assign o_qa = r_va ? r_qa : rst_val(r_ra, i_stack_start, i_sentinel);
    assign o_qb = r_vb ? r_qb : rst_val(r_rb, i_stack_start, i_sentinel);

endmodule

[sv/msc_dmem.sv]
// Data memory: MEM_DEPTH words in a synchronous RAM with a registered read port and a
// write port, swept to zero one word per cycle after reset. Depends on msc_pkg.
`timescale 1ns / 1ps

module msc_dmem #(
    parameter int MEM_DEPTH = msc_pkg::MEM_DEPTH_DEF,
    localparam int AW = $clog2(MEM_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic          i_re,
    input  logic [AW-1:0] i_addr,
    input  logic [31:0]   i_wd,
    output logic [31:0]   o_q,
    output logic          o_busy
);

    localparam logic [AW-1:0] LAST = AW'(MEM_DEPTH - 1);

    logic [31:0]   mem [MEM_DEPTH];
    logic [31:0]   r_q;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= 32'd0;
        end else if (i_we) begin
            mem[i_addr] <= i_wd;
        end
        if (i_re) begin
            r_q <= mem[i_addr];
        end
    end

    assign o_q    = r_q;
    assign o_busy = r_clr_busy;

endmodule

[sv/msc_addr_mod.sv]
// Word index unit: reduces a non-faulting word address modulo MEM_DEPTH. A power-of-two
// depth is a mask; any other depth uses a reciprocal multiply and one correction step.
// Depends on msc_pkg.
`timescale 1ns / 1ps

module msc_addr_mod #(
    parameter int MEM_DEPTH = msc_pkg::MEM_DEPTH_DEF,
    localparam int AW = $clog2(MEM_DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req,
    input  logic                          i_clear,
    input  logic [msc_pkg::ADDR_SRC_W-1:0] i_addr,
    output logic                          o_done,
    output logic [AW-1:0]                 o_index
);

    localparam bit IS_POW2 = (MEM_DEPTH & (MEM_DEPTH - 1)) == 0;

    generate
        if (IS_POW2) begin : g_mask
            assign o_done  = 1'b1;
            assign o_index = i_addr[AW-1:0];
        end else begin : g_recip
            // The estimated quotient is the true one or one less, so a single
            // compare and subtract brings the remainder into range.
            localparam int SW = msc_pkg::ADDR_SRC_W;
            localparam int SH = SW + AW;
            localparam int MW = SW + 1;
            localparam int PW = SW + MW;
            localparam logic [MW-1:0] RECIP   = MW'((64'd1 << SH) / 64'(MEM_DEPTH));
            localparam logic [SW-1:0] DEPTH_C = SW'(MEM_DEPTH);

            logic          r_busy;
            logic          r_step;
            logic          r_done;
            logic [SW-1:0] r_src;
            logic [SW-1:0] r_quo;
            logic [AW-1:0] r_rem;
            logic [PW-1:0] quo_prod;
            logic [SW-1:0] quo_est;
            logic [SW-1:0] back_prod;
            logic [SW-1:0] rem_raw;
            logic [SW-1:0] n_rem;

            always_comb begin
                quo_prod  = PW'(r_src) * PW'(RECIP);
                quo_est   = SW'(quo_prod >> SH);
                back_prod = r_quo * DEPTH_C;
                rem_raw   = r_src - back_prod;
                n_rem     = (rem_raw >= DEPTH_C) ? rem_raw - DEPTH_C : rem_raw;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_step <= 1'b0;
                    r_done <= 1'b0;
                end else if (i_clear) begin
                    r_done <= 1'b0;
                end else if (r_busy) begin
                    r_step <= 1'b1;
                    if (r_step) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end else if (i_req && !r_done) begin
                    r_busy <= 1'b1;
                    r_step <= 1'b0;
                end
            end

            always_ff @(posedge i_clk) begin
                if (r_busy) begin
                    if (!r_step) begin
                        r_quo <= quo_est;
                    end else begin
                        r_rem <= n_rem[AW-1:0];
                    end
                end else if (i_req && !r_done) begin
                    r_src <= i_addr;
                end
            end

            assign o_done  = r_done;
            assign o_index = r_rem;
        end
    endgenerate

endmodule
